[rtl/cesd_pkg.sv]
package cesd_pkg;

  // field widths
  localparam int CMD_W    = 3;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;
  localparam int CNT_W    = 16;
  localparam int SUM_W    = 32;
  localparam int MS_W     = 45;

  // input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE     = 3'd0,
    CMD_SAMPLE_END = 3'd1,
    CMD_END        = 3'd2,
    CMD_CANCEL     = 3'd3,
    CMD_RESET      = 3'd4
  } cmd_t;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHUNK       = 2'd1;
  localparam logic [IDX_W-1:0] REG_THRESHOLD   = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] RATE_RESET      = 16'd16000;
  localparam logic [CFG_W-1:0] CHUNK_RESET     = 16'd16000;
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd200;

  // rate clamp and time scale
  localparam logic [CFG_W-1:0] RATE_MIN = 16'd8000;
  localparam logic [CFG_W-1:0] RATE_MAX = 16'd48000;
  localparam int MS_PER_S     = 1000;
  localparam int MS_SCALE_W   = 10;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_DECIDE,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic mult;
    logic decide;
    logic load_a;
    logic load_b;
    logic div_step;
    logic store;
    logic sel_end;
    logic out_write;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic close;
    logic emit;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

[rtl/cesd_in_if.sv]
interface cesd_in_if;
  import cesd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink (input valid, input cmd, input sample, output ready);
endinterface

[rtl/cesd_out_if.sv]
interface cesd_out_if;
  import cesd_pkg::*;

  logic            valid;
  logic            ready;
  logic            is_final;
  logic            speech;
  logic [MS_W-1:0] first_ms;
  logic [MS_W-1:0] end_ms;

  modport source (output valid, output is_final, output speech, output first_ms,
                  output end_ms, input ready);
  modport sink (input valid, input is_final, input speech, input first_ms,
                input end_ms, output ready);
endinterface

[rtl/cesd_cfg_if.sv]
interface cesd_cfg_if;
  import cesd_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/chunked_energy_speech_detector_core.sv]
// Energy-based speech detector over fixed-size chunks of PCM samples.
// audio channel: one item per sample or command (sample, sample ending the
//   stream, end of stream, cancel, counter reset), accepted on valid && ready.
// result channel: one item per speech chunk and per final chunk, carrying the
//   final and speech flags and the chunk start and end times in ms.
// cfg channel: writes sample rate, chunk size and speech threshold; always
//   ready, meant to be used while the block is idle.
// Timing: samples that do not close their chunk stream at one per clock. A
//   close that emits nothing passes through the multiply and decide states.
//   A close with a result also runs the shared restoring divider, which
//   converts the start and then the end sample count to ms, one quotient bit
//   per cycle over COUNTER_BITS + 10 bits.
// The result sits in an output register; the block goes on accepting items
//   while it waits, and holds at the next result until the receiver takes
//   the pending one.
// Reset clears the chunk, the sample counter and the output, and loads the
//   register defaults (16000 Hz, 16000-sample chunks, threshold 200).
module chunked_energy_speech_detector_core #(
  parameter int COUNTER_BITS = 48
) (
  input logic        clk,
  input logic        rst,
  cesd_in_if.sink    audio,
  cesd_out_if.source result,
  cesd_cfg_if.sink   cfg
);
  import cesd_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // sequencer
  cesd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (audio.valid),
    .in_ready (audio.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // accumulator, divider and output register
  cesd_dp #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (audio.cmd),
    .in_sample (audio.sample),
    .ctl       (ctl),
    .stat      (stat),
    .cfg       (cfg),
    .result    (result)
  );

endmodule

[rtl/cesd_ctrl.sv]
module cesd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cesd_pkg::stat_t stat,
  output cesd_pkg::ctl_t  ctl
);
  import cesd_pkg::*;

  state_t state, state_next;
  logic   phase_end, phase_end_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase_end <= 1'b0;
    end else begin
      state     <= state_next;
      phase_end <= phase_end_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    phase_end_next = phase_end;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && stat.close) state_next = ST_MULT;
      end
      ST_MULT: state_next = ST_DECIDE;
      ST_DECIDE: begin
        phase_end_next = 1'b0;
        state_next     = stat.emit ? ST_LOAD_A : ST_IDLE;
      end
      ST_LOAD_A: state_next = ST_LOAD_B;
      ST_LOAD_B: state_next = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) state_next = ST_STORE;
      end
      ST_STORE: begin
        if (phase_end) begin
          state_next = ST_OUT;
        end else begin
          phase_end_next = 1'b1;
          state_next     = ST_LOAD_A;
        end
      end
      ST_OUT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready      = (state == ST_IDLE);
    ctl           = '0;
    ctl.sel_end   = phase_end;
    unique case (state)
      ST_IDLE:   ctl.accept    = in_valid;
      ST_MULT:   ctl.mult      = 1'b1;
      ST_DECIDE: ctl.decide    = 1'b1;
      ST_LOAD_A: ctl.load_a    = 1'b1;
      ST_LOAD_B: ctl.load_b    = 1'b1;
      ST_DIV:    ctl.div_step  = 1'b1;
      ST_STORE:  ctl.store     = 1'b1;
      ST_OUT:    ctl.out_write = stat.out_free;
      default:   ctl.accept    = 1'b0;
    endcase
  end

endmodule

[rtl/cesd_dp.sv]
module cesd_dp #(
  parameter int COUNTER_BITS = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [cesd_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [cesd_pkg::SAMPLE_W-1:0] in_sample,
  input  cesd_pkg::ctl_t                       ctl,
  output cesd_pkg::stat_t                      stat,
  cesd_cfg_if.sink                             cfg,
  cesd_out_if.source                           result
);
  import cesd_pkg::*;

  localparam int DW  = COUNTER_BITS + MS_SCALE_W;
  localparam int DCW = $clog2(DW);
  localparam int XW  = (DW > MS_W) ? DW : MS_W + 1;

  logic [CFG_W-1:0]        rate_reg, chunk_reg, thr_reg;
  logic [CNT_W-1:0]        chunk_count;
  logic [SUM_W-1:0]        abs_sum;
  logic [COUNTER_BITS-1:0] total_samples, start_samples;
  logic                    final_r, speech_r;
  logic [SUM_W:0]          prod;
  logic [DW-1:0]           dvd;
  logic [CFG_W-1:0]        rem;
  logic [DCW-1:0]          div_cnt;
  logic [MS_W-1:0]         first_ms_r, end_ms_r;
  logic                    out_valid;

  logic [SAMPLE_W:0]       mag;
  logic [CNT_W-1:0]        count_inc, limit;
  logic [COUNTER_BITS:0]   total_sum;
  logic [COUNTER_BITS-1:0] total_sat, conv_src;
  logic [DW-1:0]           src_ext;
  logic [CFG_W-1:0]        rate_eff;
  logic [CFG_W:0]          rem_sh;
  logic                    ge, speech_now;
  logic [XW-1:0]           q_ext;
  logic [MS_W-1:0]         ms_val;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_reg  <= RATE_RESET;
      chunk_reg <= CHUNK_RESET;
      thr_reg   <= THRESHOLD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SAMPLE_RATE: rate_reg  <= cfg.data;
        REG_CHUNK:       chunk_reg <= cfg.data;
        REG_THRESHOLD:   thr_reg   <= cfg.data;
        default:         rate_reg  <= rate_reg;
      endcase
    end
  end

  // sample magnitude and close decision
  assign mag = in_sample[SAMPLE_W-1]
             ? (17'h10000 - {1'b0, in_sample[SAMPLE_W-1:0]})
             : {1'b0, in_sample[SAMPLE_W-1:0]};
  assign count_inc = chunk_count + 1'b1;
  assign limit     = (chunk_reg == '0) ? CNT_W'(1) : chunk_reg;

  always_comb begin
    stat.close = 1'b0;
    unique case (in_cmd)
      CMD_SAMPLE:     stat.close = (count_inc >= limit);
      CMD_SAMPLE_END: stat.close = 1'b1;
      CMD_END:        stat.close = 1'b1;
      default:        stat.close = 1'b0;
    endcase
  end

  // speech test without division: mean > thr  <=>  sum >= (thr + 1) * count
  assign speech_now = (chunk_count != '0) && ({1'b0, abs_sum} >= prod);
  assign stat.emit  = speech_now || final_r;

  // saturating sample counter
  assign total_sum = {1'b0, total_samples} + (COUNTER_BITS + 1)'(chunk_count);
  assign total_sat = total_sum[COUNTER_BITS] ? '1 : total_sum[COUNTER_BITS-1:0];

  // chunk accumulator and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count   <= '0;
      abs_sum       <= '0;
      total_samples <= '0;
      final_r       <= 1'b0;
    end else if (ctl.accept) begin
      final_r <= (in_cmd == CMD_SAMPLE_END) || (in_cmd == CMD_END);
      unique case (in_cmd)
        CMD_SAMPLE, CMD_SAMPLE_END: begin
          abs_sum     <= abs_sum + SUM_W'(mag);
          chunk_count <= count_inc;
        end
        CMD_CANCEL: begin
          abs_sum     <= '0;
          chunk_count <= '0;
        end
        CMD_RESET: begin
          abs_sum       <= '0;
          chunk_count   <= '0;
          total_samples <= '0;
        end
        default: abs_sum <= abs_sum;
      endcase
    end else if (ctl.decide) begin
      total_samples <= total_sat;
      abs_sum       <= '0;
      chunk_count   <= '0;
    end
  end

  // threshold product and chunk snapshot
  always_ff @(posedge clk) begin
    if (ctl.mult) begin
      prod <= (SUM_W + 1)'({1'b0, thr_reg} + 17'd1) * (SUM_W + 1)'(chunk_count);
    end
    if (ctl.decide) begin
      speech_r      <= speech_now;
      start_samples <= total_samples;
    end
  end

  // clamped rate
  always_comb begin
    if (rate_reg < RATE_MIN) begin
      rate_eff = RATE_MIN;
    end else if (rate_reg > RATE_MAX) begin
      rate_eff = RATE_MAX;
    end else begin
      rate_eff = rate_reg;
    end
  end

  // samples * 1000 / rate, one quotient bit a cycle
  assign conv_src = ctl.sel_end ? total_samples : start_samples;
  assign src_ext  = DW'(conv_src);
  assign rem_sh   = {rem, dvd[DW-1]};
  assign ge       = (rem_sh >= {1'b0, rate_eff});
  assign stat.div_done = (div_cnt == DCW'(DW - 1));

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      dvd     <= (src_ext << 10) - (src_ext << 4);
      rem     <= '0;
      div_cnt <= '0;
    end else if (ctl.load_b) begin
      dvd <= dvd - (src_ext << 3);
    end else if (ctl.div_step) begin
      rem     <= ge ? CFG_W'(rem_sh - {1'b0, rate_eff}) : rem_sh[CFG_W-1:0];
      dvd     <= {dvd[DW-2:0], ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // saturate quotient to the ms field
  assign q_ext  = XW'(dvd);
  assign ms_val = (|q_ext[XW-1:MS_W]) ? '1 : q_ext[MS_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.store) begin
      if (ctl.sel_end) begin
        end_ms_r <= ms_val;
      end else begin
        first_ms_r <= ms_val;
      end
    end
  end

  // output register
  assign stat.out_free = !out_valid || result.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_write) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_write) begin
      result.is_final <= final_r;
      result.speech   <= speech_r;
      result.first_ms <= first_ms_r;
      result.end_ms   <= end_ms_r;
    end
  end

  assign result.valid = out_valid;

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_write |-> (!out_valid || result.ready))
    else $error("result written while output register held");

  // closing a chunk empties the accumulator
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.decide |=> (chunk_count == '0 && abs_sum == '0))
    else $error("chunk state not cleared at close");

  // the sample counter never goes back at a close
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    ctl.decide |=> (total_samples >= $past(total_samples)))
    else $error("sample counter decreased at close");

endmodule
